@@ hdl/dsft_pkg.sv @@
// ----------------------------------------------------------------------------
// dsft_pkg
// Shared constants, register indexes and status codes of the DShot transmitter.
// ----------------------------------------------------------------------------
package dsft_pkg;

    localparam int FRAME_SLOTS_DEF = 18;
    localparam int DATA_BITS       = 16;
    localparam int THR_W           = 11;
    localparam int TICK_W          = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_ADDR_W      = 2;

    localparam logic [TICK_W-1:0] PERIOD_RST    = 16'd426;
    localparam logic [TICK_W-1:0] HIGH_ONE_RST  = 16'd320;
    localparam logic [TICK_W-1:0] HIGH_ZERO_RST = 16'd160;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PERIOD    = 2'd0,
        REG_HIGH_ONE  = 2'd1,
        REG_HIGH_ZERO = 2'd2,
        REG_TELEMETRY = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2
    } send_status_t;

endpackage

@@ hdl/dshot_frame_pulse_transmitter.sv @@
// ----------------------------------------------------------------------------
// dshot_frame_pulse_transmitter
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle; a single output register holds the result and
// the input is taken whenever that register is empty or being drained.
// Reset (synchronous, active low) restores the default timing registers and
// leaves the line idle with no frame in progress.
// ----------------------------------------------------------------------------
module dshot_frame_pulse_transmitter
    import dsft_pkg::*;
#(
    parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [10:0] throttle
    input  logic                  s_tuser,   // [0] op (1 = send)
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata    // [0] line_level, [1] busy_res,
                                             // [3:2] send_status
);

    localparam int SLOT_W = $clog2(FRAME_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
    localparam logic [SLOT_W-1:0] DATA_END  = SLOT_W'(DATA_BITS);

    logic [TICK_W-1:0]    period_reg, high_one_reg, high_zero_reg;
    logic                 telem_reg;

    logic [DATA_BITS-1:0] frame_reg, frame_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic                 sending_reg, sending_next;

    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;

    logic [DATA_BITS-1:0] new_frame;
    logic                 accept;
    logic                 level;
    logic                 busy;
    send_status_t         status;
    logic [TICK_W-1:0]    limit;

    dsft_frame_gen u_frame_gen (
        .throttle  (s_tdata[THR_W-1:0]),
        .telemetry (telem_reg),
        .frame     (new_frame)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PERIOD_RST;
            high_one_reg  <= HIGH_ONE_RST;
            high_zero_reg <= HIGH_ZERO_RST;
            telem_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_PERIOD:    period_reg    <= cfg_wdata[TICK_W-1:0];
                REG_HIGH_ONE:  high_one_reg  <= cfg_wdata[TICK_W-1:0];
                REG_HIGH_ZERO: high_zero_reg <= cfg_wdata[TICK_W-1:0];
                REG_TELEMETRY: telem_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        frame_next   = frame_reg;
        slot_next    = slot_reg;
        tick_next    = tick_reg;
        sending_next = sending_reg;
        status       = ST_NONE;

        if (s_tuser) begin
            if (sending_reg) begin
                status = ST_REJECTED;
            end else begin
                frame_next   = new_frame;
                slot_next    = '0;
                tick_next    = '0;
                sending_next = 1'b1;
                status       = ST_ACCEPTED;
            end
        end else if (sending_reg) begin
            if (tick_reg >= period_reg) begin
                tick_next  = '0;
                frame_next = {frame_reg[DATA_BITS-2:0], 1'b0};
                if (slot_reg >= LAST_SLOT) begin
                    slot_next    = '0;
                    sending_next = 1'b0;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end else begin
                tick_next = tick_reg + TICK_W'(1);
            end
        end

        // A tick reports the state it runs in; a send reports the state it enters.
        if (s_tuser) begin
            limit = frame_next[DATA_BITS-1] ? high_one_reg : high_zero_reg;
            busy  = sending_next;
            level = sending_next && (slot_next < DATA_END) && (tick_next < limit);
        end else begin
            limit = frame_reg[DATA_BITS-1] ? high_one_reg : high_zero_reg;
            busy  = sending_reg;
            level = sending_reg && (slot_reg < DATA_END) && (tick_reg < limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg     <= '0;
            slot_reg      <= '0;
            tick_reg      <= '0;
            sending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                frame_reg     <= frame_next;
                slot_reg      <= slot_next;
                tick_reg      <= tick_next;
                sending_reg   <= sending_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_data_reg <= {4'b0000, status, busy, level};
        end
    end

endmodule

@@ hdl/dsft_frame_gen.sv @@
// ----------------------------------------------------------------------------
// dsft_frame_gen
// Builds a 16-bit DShot frame: throttle, telemetry bit and nibble checksum.
// ----------------------------------------------------------------------------
module dsft_frame_gen
    import dsft_pkg::*;
(
    input  logic [THR_W-1:0]     throttle,
    input  logic                 telemetry,
    output logic [DATA_BITS-1:0] frame
);

    logic [11:0] word;
    logic [3:0]  csum;

    assign word  = {throttle, telemetry};
    assign csum  = word[3:0] ^ word[7:4] ^ word[11:8];
    assign frame = {word, csum};

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the DShot frame transmitter. Each tick or send request is
// mirrored into a scoreboard that keeps its own copy of the frame state and
// timing registers. Every returned line sample is checked against the oldest
// prediction, while both stream sides pause at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsft_pkg::*;

    localparam int CYCLE_LIMIT = 50000;

    typedef struct {
        logic         level;
        logic         busy;
        send_status_t status;
    } line_sample_t;

    class dshot_scoreboard;
        logic [TICK_W-1:0]    period;
        logic [TICK_W-1:0]    high_one;
        logic [TICK_W-1:0]    high_zero;
        logic                 telemetry;
        logic [DATA_BITS-1:0] frame;
        logic [4:0]           slot;
        logic [TICK_W-1:0]    tick;
        logic                 sending;
        line_sample_t         samples_q[$];
        int                   errors;

        function new();
            period    = PERIOD_RST;
            high_one  = HIGH_ONE_RST;
            high_zero = HIGH_ZERO_RST;
            telemetry = 1'b0;
            frame     = '0;
            slot      = '0;
            tick      = '0;
            sending   = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
            case (r)
                REG_PERIOD:    period    = v;
                REG_HIGH_ONE:  high_one  = v;
                REG_HIGH_ZERO: high_zero = v;
                REG_TELEMETRY: telemetry = v[0];
                default: ;
            endcase
        endfunction

        // Throttle and telemetry bit, followed by the XOR of their three nibbles.
        function logic [DATA_BITS-1:0] dshot_frame(logic [THR_W-1:0] thr);
            logic [11:0] word;
            logic [3:0]  csum;
            word = {thr, telemetry};
            csum = word[3:0] ^ word[7:4] ^ word[11:8];
            return {word, csum};
        endfunction

        function logic level_now();
            logic [TICK_W-1:0] limit;
            if (!sending || slot >= DATA_BITS) return 1'b0;
            limit = frame[DATA_BITS-1] ? high_one : high_zero;
            return tick < limit;
        endfunction

        function int pending();
            return samples_q.size();
        endfunction

        function void note_request(logic op, logic [THR_W-1:0] thr);
            line_sample_t s;
            s.status = ST_NONE;
            if (op) begin
                if (sending) begin
                    s.status = ST_REJECTED;
                end else begin
                    frame    = dshot_frame(thr);
                    slot     = '0;
                    tick     = '0;
                    sending  = 1'b1;
                    s.status = ST_ACCEPTED;
                end
                s.level = level_now();
                s.busy  = sending;
            end else begin
                s.level = level_now();
                s.busy  = sending;
                if (sending) begin
                    if (tick >= period) begin
                        tick  = '0;
                        frame = frame << 1;
                        if (slot >= FRAME_SLOTS_DEF - 1) begin
                            slot    = '0;
                            sending = 1'b0;
                        end else begin
                            slot = slot + 5'd1;
                        end
                    end else begin
                        tick = tick + TICK_W'(1);
                    end
                end
            end
            samples_q.push_back(s);
        endfunction

        function void check_result(logic [7:0] d);
            line_sample_t s;
            if (samples_q.size() == 0) begin
                $error("unexpected result 0x%02h", d);
                errors++;
                return;
            end
            s = samples_q.pop_front();
            if (d[0] !== s.level) begin
                $error("line_level expected %0d got %0d", s.level, d[0]);
                errors++;
            end
            if (d[1] !== s.busy) begin
                $error("busy_res expected %0d got %0d", s.busy, d[1]);
                errors++;
            end
            if (d[3:2] !== s.status) begin
                $error("send_status expected %0d got %0d", s.status, d[3:2]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;  // [10:0] throttle
    logic                  s_tuser   = 1'b0; // [0] op (1 = send)
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;         // [0] line_level, [1] busy_res,
                                            // [3:2] send_status

    dshot_scoreboard sb = new();
    bit  calm = 1'b0;
    int  cycles = 0;

    dshot_frame_pulse_transmitter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready = calm || ($urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic push_item(input logic op, input logic [THR_W-1:0] thr);
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 15) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {5'd0, thr};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, thr);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = r;
        cfg_wdata = v;
        @(posedge aclk);
        sb.set_reg(r, v);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic write_timing(input logic [CFG_W-1:0] per, input logic [CFG_W-1:0] hi1,
                                input logic [CFG_W-1:0] hi0, input logic [CFG_W-1:0] tel);
        drain();
        write_reg(REG_PERIOD, per);
        write_reg(REG_HIGH_ONE, hi1);
        write_reg(REG_HIGH_ZERO, hi0);
        write_reg(REG_TELEMETRY, tel);
    endtask

    // Ticks carry random throttle bits, which the block must ignore.
    task automatic finish_frame();
        while (sb.sending) push_item(1'b0, THR_W'($urandom_range(2047, 0)));
    endtask

    function automatic logic [CFG_W-1:0] pick_high(input int per);
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return CFG_W'($urandom_range(per + 2, 0));
        endcase
    endfunction

    function automatic logic [THR_W-1:0] pick_throttle();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return 11'h7FF;
            default: return THR_W'($urandom_range(2047, 0));
        endcase
    endfunction

    initial begin
        int per;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset timing: idle tick, the start of a frame and a request refused while
        // busy. The frame then runs to its end under a short slot.
        push_item(1'b0, 11'h7FF);
        push_item(1'b1, 11'h7FF);
        push_item(1'b1, 11'h000);
        repeat (12) push_item(1'b0, 11'h000);

        write_timing(16'd3, 16'd2, 16'd1, 16'hFFFF);
        finish_frame();
        push_item(1'b0, 11'h000);
        push_item(1'b1, 11'h000);
        finish_frame();
        push_item(1'b1, 11'h7FF);
        finish_frame();
        push_item(1'b1, 11'h555);
        push_item(1'b0, 11'h000);
        push_item(1'b1, 11'h2AA);
        finish_frame();
        push_item(1'b1, 11'h2AA);
        finish_frame();

        // Zero high time keeps every slot low; a high time past the slot keeps it high.
        write_timing(16'd0, 16'd0, 16'd0, 16'h0000);
        push_item(1'b1, 11'h7FF);
        finish_frame();
        write_timing(16'd0, 16'hFFFF, 16'hFFFF, 16'h0001);
        push_item(1'b1, 11'h400);
        finish_frame();

        for (int ph = 0; ph < 6; ph++) begin
            per = (ph == 3) ? 8 : $urandom_range(4, 0);
            write_timing(CFG_W'(per), pick_high(per), pick_high(per),
                         CFG_W'($urandom_range(65535, 0)));
            calm = (ph == 3);
            repeat (40) begin
                if (!sb.sending && $urandom_range(99) < 30)
                    push_item(1'b1, pick_throttle());
                else if ($urandom_range(99) < 5)
                    push_item(1'b1, pick_throttle());
                else
                    push_item(1'b0, THR_W'($urandom_range(2047, 0)));
            end
            finish_frame();
            calm = 1'b0;
        end

        // Widest slot: a frame starts, a request is refused, and the frame then
        // finishes under a short slot.
        write_timing(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
        push_item(1'b1, 11'h6F3);
        calm = 1'b1;
        repeat (20) push_item(1'b0, THR_W'($urandom_range(2047, 0)));
        calm = 1'b0;
        push_item(1'b1, 11'h123);
        repeat (20) push_item(1'b0, THR_W'($urandom_range(2047, 0)));
        write_timing(16'd1, 16'd1, 16'd2, 16'h0000);
        finish_frame();

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
